@@ sv/hdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_pkg - shared types and constants of the tabular hijri date converter
// Field widths, reciprocal constants for the fixed divisions, the month start
// table and the structs that travel between pipeline parts.
// ----------------------------------------------------------------------------
package hdc_pkg;

    localparam int MAX_YEAR_DEF = 9999;

    // pipeline register stages from input capture to output register
    localparam int NS = 6;

    localparam int YW    = 14;  // year
    localparam int MW    = 4;   // month
    localparam int DW    = 5;   // day
    localparam int CW    = 22;  // day count
    localparam int DOYW  = 9;   // day in year
    localparam int YIW   = YW + 1;  // candidate year, room for +2
    localparam int YSW   = 23;  // days before a year, up to year 16384
    localparam int REM_W = 9;   // days into the year, from 0
    localparam int XW    = 19;  // 11*y + 3
    localparam int PW30  = 36;  // (x >> 1) * DIV15_MULT
    localparam int Q30W  = 15;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam int MONTHS = 12;
    localparam int LEAP_REM_MIN = 19;

    // floor(n / 15) = (n * DIV15_MULT) >> DIV15_SHIFT, exact for n < 161319
    localparam int DIV15_SHIFT = 21;
    localparam int DIV15_MULT  = ((1 << DIV15_SHIFT) + 14) / 15;

    // year estimate: count * 30 / 10631 in fixed point
    localparam int EST_SHIFT = 24;
    localparam int EST_MW    = 16;
    localparam int EST_MULT  = (30 * (1 << EST_SHIFT) + 10631 / 2) / 10631;
    localparam int EPW       = CW + EST_MW;

    typedef struct packed {
        logic [NS-1:0] load;
        logic [NS-1:0] valid;
    } hdc_pipe_t;

    typedef struct packed {
        logic          action;
        logic          err;
        logic [YW-1:0] iy;
        logic [MW-1:0] im;
        logic [DW-1:0] id;
        logic [CW-1:0] ik;
    } hdc_carry_t;

    typedef struct packed {
        logic             action;
        logic             err;
        logic [YW-1:0]    year;
        logic [REM_W-1:0] rem;
        logic [CW-1:0]    cnt;
        logic             leap;
        logic [MW-1:0]    im;
        logic [DW-1:0]    id;
    } hdc_sel_t;

    // days before month m: 29*(m-1) + m/2
    function automatic logic [DOYW-1:0] month_start(input logic [MW-1:0] m);
        logic [DOYW-1:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd30;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd89;
            4'd5:    v = 9'd118;
            4'd6:    v = 9'd148;
            4'd7:    v = 9'd177;
            4'd8:    v = 9'd207;
            4'd9:    v = 9'd236;
            4'd10:   v = 9'd266;
            4'd11:   v = 9'd295;
            4'd12:   v = 9'd325;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/tabular_hijri_date_converter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_hijri_date_converter_core - tabular hijri date <-> day count
// Converts a hijri date to days since 1 Muharram 1 AH or back, with leap
// flag, day of year and range check, in a six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)                      tuser
//  s_*      in   in_year, in_month, in_day, in_day_count        action
//  m_*      out  day_count, year, month, day, day_in_year,      range_error
//                leap_year
//
//  one transaction per cycle, unless m_tready stalls the output, through six
//  register stages: capture, year estimate multiply, year start products, year
//  start sums, year select and count, month search, whose register drives m_*
//  reset clears only the stage valid bits; the pipeline is empty after reset
//  a stall holds each full stage whose successor holds; empty stages still fill
// ----------------------------------------------------------------------------
module tabular_hijri_date_converter_core #(
    parameter int MAX_YEAR = hdc_pkg::MAX_YEAR_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // in_year, in_month, in_day, in_day_count, zero fill
    input  wire logic [hdc_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // day_count, year, month, day, day_in_year, leap_year, zero fill
    output logic [hdc_pkg::M_TDATA_W-1:0]       m_tdata,
    // range_error
    output logic                                m_tuser
);
    import hdc_pkg::*;

    // first day of year MAX_YEAR + 1
    localparam int LIMIT_I = MAX_YEAR * 354 + (3 + 11 * (MAX_YEAR + 1)) / 30;
    localparam logic [YSW-1:0] COUNT_LIMIT = YSW'(LIMIT_I);
    localparam logic [YW-1:0]  YEAR_MAX    = YW'(MAX_YEAR);

    hdc_pipe_t ctl;

    // stage 0: input capture
    logic          act0_reg;
    logic [YW-1:0] iy0_reg;
    logic [MW-1:0] im0_reg;
    logic [DW-1:0] id0_reg;
    logic [CW-1:0] ik0_reg;

    // stage 1: range check and year estimate product
    hdc_carry_t     c1_reg, c1_next;
    logic [EPW-1:0] est1_reg, est1_next;

    // stage 2 and 3: year start units
    hdc_carry_t     c2_reg, c3_reg;
    logic [YIW-1:0] yb2_reg, yb2_next, yb3_reg;
    logic [YW-1:0]  q_est;
    logic [YSW-1:0] ys [3];
    logic           lp [3];

    // stage 4: year select and count
    hdc_sel_t       sel4_reg, sel4_next;
    logic [YSW-1:0] ik_ext;
    logic           ge1, ge2;
    logic [YIW-1:0] y_rev;
    logic [YSW-1:0] ys_rev;
    logic           lp_rev;
    logic [YSW:0]   fwd_cnt;

    logic [CW-1:0]   o_cnt;
    logic [YW-1:0]   o_year;
    logic [MW-1:0]   o_month;
    logic [DW-1:0]   o_day;
    logic [DOYW-1:0] o_doy;
    logic            o_leap;
    logic            o_err;

    hdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .ctl       (ctl)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            act0_reg <= s_tuser;
            iy0_reg  <= s_tdata[13:0];
            im0_reg  <= s_tdata[17:14];
            id0_reg  <= s_tdata[22:18];
            ik0_reg  <= s_tdata[44:23];
        end
    end

    always_comb
    begin
        c1_next.action = act0_reg;
        c1_next.iy     = iy0_reg;
        c1_next.im     = im0_reg;
        c1_next.id     = id0_reg;
        c1_next.ik     = ik0_reg;
        if (act0_reg)
        begin
            c1_next.err = YSW'(ik0_reg) >= COUNT_LIMIT;
        end
        else
        begin
            c1_next.err = (iy0_reg == '0) || (iy0_reg > YEAR_MAX) || (im0_reg == '0)
                       || (im0_reg > MW'(MONTHS)) || (id0_reg == '0);
        end
        est1_next = EPW'(ik0_reg) * EPW'(EST_MULT);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            c1_reg   <= c1_next;
            est1_reg <= est1_next;
        end
    end

    // the true year is the estimate, or one or two above it
    assign q_est    = YW'(est1_reg >> EST_SHIFT);
    assign yb2_next = c1_reg.action ? YIW'(q_est) : YIW'(c1_reg.iy);

    for (genvar j = 0; j < 3; j++)
    begin : g_ys
        hdc_year_start u_ys (
            .clk  (clk),
            .en_a (ctl.load[2]),
            .en_b (ctl.load[3]),
            .y    (yb2_next + YIW'(j)),
            .ys   (ys[j]),
            .leap (lp[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            c2_reg  <= c1_reg;
            yb2_reg <= yb2_next;
        end
        if (ctl.load[3])
        begin
            c3_reg  <= c2_reg;
            yb3_reg <= yb2_reg;
        end
    end

    always_comb
    begin
        ik_ext = YSW'(c3_reg.ik);
        ge1    = ys[1] <= ik_ext;
        ge2    = ys[2] <= ik_ext;
        if (ge2)
        begin
            y_rev  = yb3_reg + YIW'(2);
            ys_rev = ys[2];
            lp_rev = lp[2];
        end
        else if (ge1)
        begin
            y_rev  = yb3_reg + YIW'(1);
            ys_rev = ys[1];
            lp_rev = lp[1];
        end
        else
        begin
            y_rev  = yb3_reg;
            ys_rev = ys[0];
            lp_rev = lp[0];
        end
        fwd_cnt = (YSW+1)'(ys[0]) + (YSW+1)'(month_start(c3_reg.im))
                + (YSW+1)'(c3_reg.id) - (YSW+1)'(1);

        sel4_next.action = c3_reg.action;
        sel4_next.im     = c3_reg.im;
        sel4_next.id     = c3_reg.id;
        sel4_next.rem    = REM_W'(ik_ext - ys_rev);
        if (c3_reg.action)
        begin
            sel4_next.err  = c3_reg.err;
            sel4_next.year = y_rev[YW-1:0];
            sel4_next.cnt  = c3_reg.ik;
            sel4_next.leap = lp_rev;
        end
        else
        begin
            // a count past 22 bits is rejected
            sel4_next.err  = c3_reg.err || (fwd_cnt[YSW:CW] != '0);
            sel4_next.year = c3_reg.iy;
            sel4_next.cnt  = fwd_cnt[CW-1:0];
            sel4_next.leap = lp[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            sel4_reg <= sel4_next;
        end
    end

    hdc_date_out u_out (
        .clk         (clk),
        .en          (ctl.load[5]),
        .sel         (sel4_reg),
        .day_count   (o_cnt),
        .year        (o_year),
        .month       (o_month),
        .day         (o_day),
        .day_in_year (o_doy),
        .leap_year   (o_leap),
        .range_error (o_err)
    );

    assign m_tvalid = ctl.valid[NS-1];
    assign m_tdata  = {1'b0, o_leap, o_doy, o_day, o_month, o_year, o_cnt};
    assign m_tuser  = o_err;

endmodule
`default_nettype wire

@@ sv/hdc_pipe_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_pipe_ctrl - valid and load control of the conversion pipeline
// Each stage loads when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module hdc_pipe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output logic                   in_ready,
    output hdc_pkg::hdc_pipe_t     ctl
);
    import hdc_pkg::*;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] ready;

    always_comb
    begin
        ready[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ready[0];
    assign ctl.load  = ready;
    assign ctl.valid = valid_reg;

endmodule
`default_nettype wire

@@ sv/hdc_year_start.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_year_start - days before a hijri year and its leap flag
// Two register stages: products first, then the sum and the remainder test.
// ----------------------------------------------------------------------------
module hdc_year_start (
    input  wire logic                   clk,
    input  wire logic                   en_a,
    input  wire logic                   en_b,
    input  wire logic [hdc_pkg::YIW-1:0] y,
    output logic [hdc_pkg::YSW-1:0]     ys,
    output logic                        leap
);
    import hdc_pkg::*;

    logic [YIW-1:0]  y_m1;
    logic [YSW-1:0]  mul354_reg, mul354_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [PW30-1:0] prod30_reg, prod30_next;
    logic [Q30W-1:0] q30;
    logic [XW-1:0]   r30;
    logic [YSW-1:0]  ys_reg, ys_next;
    logic            leap_reg, leap_next;

    always_comb
    begin
        y_m1        = y - YIW'(1);
        mul354_next = YSW'(YSW'(y_m1) * YSW'(354));
        x_next      = XW'(XW'(y) * XW'(11) + XW'(3));
        // floor(x / 30) taken as floor((x >> 1) / 15)
        prod30_next = PW30'(x_next[XW-1:1]) * PW30'(DIV15_MULT);
    end

    always_comb
    begin
        q30     = Q30W'(prod30_reg >> DIV15_SHIFT);
        ys_next = mul354_reg + YSW'(q30);
        // (11y+3) mod 30 >= 19 is the same as (11y+14) mod 30 < 11
        r30       = x_reg - XW'(XW'(q30) * XW'(30));
        leap_next = r30 >= XW'(LEAP_REM_MIN);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mul354_reg <= mul354_next;
            x_reg      <= x_next;
            prod30_reg <= prod30_next;
        end
        if (en_b)
        begin
            ys_reg   <= ys_next;
            leap_reg <= leap_next;
        end
    end

    assign ys   = ys_reg;
    assign leap = leap_reg;

endmodule
`default_nettype wire

@@ sv/hdc_date_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_date_out - month search and output register
// Splits the day of year into month and day, or forms the day of year from a
// given date, and clears the fields of a rejected transaction.
// ----------------------------------------------------------------------------
module hdc_date_out (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire hdc_pkg::hdc_sel_t        sel,
    output logic [hdc_pkg::CW-1:0]        day_count,
    output logic [hdc_pkg::YW-1:0]        year,
    output logic [hdc_pkg::MW-1:0]        month,
    output logic [hdc_pkg::DW-1:0]        day,
    output logic [hdc_pkg::DOYW-1:0]      day_in_year,
    output logic                          leap_year,
    output logic                          range_error
);
    import hdc_pkg::*;

    logic [MW-1:0]   m_search;
    logic [DOYW-1:0] ms_search;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [YW-1:0]   year_reg, year_next;
    logic [MW-1:0]   month_reg, month_next;
    logic [DW-1:0]   day_reg, day_next;
    logic [DOYW-1:0] doy_reg, doy_next;
    logic            leap_reg, leap_next;
    logic            err_reg, err_next;

    always_comb
    begin
        // month starts rise, so the month is one plus the later starts passed
        m_search = MW'(1);
        for (int k = 2; k <= MONTHS; k++)
        begin
            if (month_start(MW'(k)) <= sel.rem)
            begin
                m_search = m_search + MW'(1);
            end
        end
        ms_search = month_start(m_search);

        cnt_next   = sel.cnt;
        year_next  = sel.year;
        leap_next  = sel.leap;
        err_next   = sel.err;
        if (sel.action)
        begin
            month_next = m_search;
            day_next   = DW'(sel.rem - ms_search + REM_W'(1));
            doy_next   = DOYW'(sel.rem) + DOYW'(1);
        end
        else
        begin
            month_next = sel.im;
            day_next   = sel.id;
            doy_next   = month_start(sel.im) + DOYW'(sel.id);
        end
        if (sel.err)
        begin
            cnt_next   = '0;
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
            doy_next   = '0;
            leap_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg   <= cnt_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            doy_reg   <= doy_next;
            leap_reg  <= leap_next;
            err_reg   <= err_next;
        end
    end

    assign day_count   = cnt_reg;
    assign year        = year_reg;
    assign month       = month_reg;
    assign day         = day_reg;
    assign day_in_year = doy_reg;
    assign leap_year   = leap_reg;
    assign range_error = err_reg;

endmodule
`default_nettype wire
